### design/cur_pkg.sv
// Shared constants, codes and types of the chunked update receiver.
package cur_pkg;

    // Map geometry: one bit per chunk, packed into rows of the map RAM
    localparam int MAX_CHUNKS = 4096;
    localparam int MAP_W      = (MAX_CHUNKS >= 64) ? 32 : 4;
    localparam int MAP_ROWS   = (MAX_CHUNKS + MAP_W - 1) / MAP_W;
    localparam int MAP_BW     = $clog2(MAP_W);
    localparam int MAP_RW     = $clog2(MAP_ROWS);

    // Field widths
    localparam int OP_W   = 3;
    localparam int TAG_W  = 32;
    localparam int TOT_W  = 13;
    localparam int SEQ_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int ADDR_W = 16;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int PH_W   = 2;
    localparam int PADDR_W = 3;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [STAT_W-1:0] t_stat;
    typedef logic [PH_W-1:0]   t_phase;

    // Opcodes
    localparam t_op OP_BEGIN = 3'd0;
    localparam t_op OP_CHUNK = 3'd1;
    localparam t_op OP_APPLY = 3'd2;
    localparam t_op OP_ABORT = 3'd3;
    localparam t_op OP_TICK  = 3'd4;

    // Result kinds
    localparam t_kind KIND_ACK    = 2'd0;
    localparam t_kind KIND_STATUS = 2'd1;
    localparam t_kind KIND_GO     = 2'd2;

    // Ack status codes
    localparam t_stat ST_OK       = 2'd0;
    localparam t_stat ST_CRC_ERR  = 2'd1;
    localparam t_stat ST_NO_SPACE = 2'd2;
    localparam t_stat ST_BAD_SEQ  = 2'd3;

    // Session phases
    localparam t_phase PH_IDLE  = 2'd0;
    localparam t_phase PH_RECV  = 2'd1;
    localparam t_phase PH_APPLY = 2'd2;

    // CRC-16 constants
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    // Register file
    localparam logic [CNT_W-1:0] TIMEOUT_RST = 32'd60000;
    localparam logic REG_TIMEOUT = 1'b0;

endpackage

### design/cur_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/cur_crc.sv
// Bit-serial CRC-16 engine: folds one byte into the CRC, one bit per cycle.
module cur_crc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cur_pkg::CRC_W-1:0]   i_crc,
    input  logic [cur_pkg::BYTE_W-1:0]  i_byte,
    output logic                        o_done,
    output logic [cur_pkg::CRC_W-1:0]   o_crc
);
    import cur_pkg::*;

    localparam int BIT_CW = $clog2(BYTE_W);

    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_sh;
    logic [BIT_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              fb;

    // Feedback: CRC top bit against the next data bit, MSB first
    assign fb = ((r_crc & CRC_TOP) != '0) ^ r_sh[BYTE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == BIT_CW'(BYTE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_crc <= i_crc;
            r_sh  <= i_byte;
        end else if (r_busy) begin
            r_crc <= {r_crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
            r_sh  <= {r_sh[BYTE_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_crc;

endmodule

### design/cur_apb.sv
// APB-style configuration port holding the idle timeout register.
module cur_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cur_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [cur_pkg::CNT_W-1:0]    o_timeout
);
    import cur_pkg::*;

    logic [CNT_W-1:0] r_timeout;
    logic             sel_timeout;

    // Register index is the word address
    assign sel_timeout = (paddr[2] == REG_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && sel_timeout) begin
            r_timeout <= pwdata;
        end
    end

    assign prdata    = sel_timeout ? r_timeout : '0;
    assign pready    = 1'b1;
    assign o_timeout = r_timeout;

endmodule

### design/chunked_update_receiver.sv
// Top level of the chunked update receiver: session sequencer, map and result register.
//
// Input items (i_valid/o_ready) carry one command each: begin, chunk byte, apply,
// abort or a millisecond tick. At most one result item leaves on o_valid/i_ready.
// The block works on one item at a time; o_ready is high only when it is idle.
// A chunk byte is folded into the CRC-16 by a bit-serial engine, one bit per
// cycle. Each accepted item is registered and then executed; a chunk byte then
// waits for the CRC engine, and the last byte of a chunk is judged before its
// result is emitted. Apply emits its result after execution; abort, tick and
// ignored items return to idle. Begin clears the received-chunk map one RAM row
// per cycle, 128 rows of 32 bits, then emits its result. Chunk flags are read and
// rewritten through the single map RAM port pair during the judgement of the last byte.
// Results sit in an output register: a new item is accepted while a result
// waits, and a finished result holds in its state until the register is free.
// A stalled receiver therefore blocks at most the item after next.
// Reset (synchronous, active low) drops any session, sets the timeout register
// to 60000 ms and empties the output register; the map is cleared by each begin.
// The user must write the timeout register through the APB port only while idle; the block does not enforce it.
module chunked_update_receiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [cur_pkg::OP_W-1:0]     i_opcode,
    input  logic [cur_pkg::TAG_W-1:0]    i_session_tag,
    input  logic [cur_pkg::TOT_W-1:0]    i_chunk_total,
    input  logic [cur_pkg::SEQ_W-1:0]    i_seq_index,
    input  logic [cur_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_last_byte,
    input  logic [cur_pkg::CRC_W-1:0]    i_chunk_crc,
    input  logic                         i_store_ok,
    input  logic [cur_pkg::ADDR_W-1:0]   i_source_addr,
    // result items
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [cur_pkg::KIND_W-1:0]   o_result_kind,
    output logic [cur_pkg::ADDR_W-1:0]   o_dest_addr,
    output logic [cur_pkg::TAG_W-1:0]    o_session_out,
    output logic [cur_pkg::SEQ_W-1:0]    o_seq_out,
    output logic [cur_pkg::STAT_W-1:0]   o_ack_status,
    output logic [cur_pkg::TOT_W-1:0]    o_chunks_done,
    output logic [cur_pkg::TOT_W-1:0]    o_chunks_total_out,
    output logic [cur_pkg::CNT_W-1:0]    o_bytes_done,
    output logic [cur_pkg::PH_W-1:0]     o_phase_out,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cur_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import cur_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_CRC   = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // control state
    logic [2:0]        r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [TAG_W-1:0]  r_session, n_session;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [TOT_W-1:0]  r_rcv, n_rcv;
    logic [CNT_W-1:0]  r_bytes, n_bytes;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_host, n_host;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [CNT_W-1:0]  r_idle, n_idle;
    logic [MAP_RW-1:0] r_row, n_row;

    // captured item
    t_op               r_op;
    logic [TAG_W-1:0]  r_tag;
    logic [TOT_W-1:0]  r_ctot;
    logic [SEQ_W-1:0]  r_seq;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [CRC_W-1:0]  r_ecrc;
    logic              r_sok;
    logic [ADDR_W-1:0] r_src;

    // pending result
    t_kind             r_res_kind, n_res_kind;
    t_stat             r_res_stat, n_res_stat;
    logic [TAG_W-1:0]  r_res_sess, n_res_sess;
    logic              r_res_seq, n_res_seq;
    logic              r_res_tot, n_res_tot;

    // output register
    logic              r_o_valid, n_o_valid;
    t_kind             r_o_kind;
    logic [ADDR_W-1:0] r_o_dest;
    logic [TAG_W-1:0]  r_o_sess;
    logic [SEQ_W-1:0]  r_o_seq;
    t_stat             r_o_stat;
    logic [TOT_W-1:0]  r_o_done;
    logic [TOT_W-1:0]  r_o_tot;
    logic [CNT_W-1:0]  r_o_bytes;
    t_phase            r_o_phase;
    logic              out_load;

    logic              in_acc;
    logic              crc_start;
    logic              crc_done;
    logic [CRC_W-1:0]  crc_out;
    logic              ram_we;
    logic [MAP_RW-1:0] ram_waddr;
    logic [MAP_W-1:0]  ram_wdata;
    logic [MAP_W-1:0]  ram_rdata;
    logic [MAP_RW-1:0] seq_row;
    logic [MAP_BW-1:0] seq_bit;
    logic [CNT_W-1:0]  timeout;
    logic [CNT_W:0]    byte_sum;
    logic [CNT_W-1:0]  idle_inc;
    logic              drop;

    cur_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (timeout)
    );

    cur_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crc_start),
        .i_crc   (r_crc),
        .i_byte  (r_byte),
        .o_done  (crc_done),
        .o_crc   (crc_out)
    );

    cur_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (seq_row),
        .o_rdata (ram_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign seq_row = r_seq[MAP_BW +: MAP_RW];
    assign seq_bit = r_seq[MAP_BW-1:0];
    assign byte_sum = {1'b0, r_bytes} + {{(CNT_W + 1 - LEN_W){1'b0}}, r_len};
    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + 1'b1;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_opcode;
            r_tag  <= i_session_tag;
            r_ctot <= i_chunk_total;
            r_seq  <= i_seq_index;
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
            r_ecrc <= i_chunk_crc;
            r_sok  <= i_store_ok;
            r_src  <= i_source_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_session  = r_session;
        n_total    = r_total;
        n_rcv      = r_rcv;
        n_bytes    = r_bytes;
        n_len      = r_len;
        n_host     = r_host;
        n_crc      = r_crc;
        n_idle     = r_idle;
        n_row      = r_row;
        n_res_kind = r_res_kind;
        n_res_stat = r_res_stat;
        n_res_sess = r_res_sess;
        n_res_seq  = r_res_seq;
        n_res_tot  = r_res_tot;
        crc_start  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = seq_row;
        ram_wdata  = ram_rdata | (MAP_W'(1) << seq_bit);
        out_load   = 1'b0;
        drop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_op)
                    OP_BEGIN: begin
                        n_phase   = PH_RECV;
                        n_session = r_tag;
                        n_total   = ({19'b0, r_ctot} > 32'(MAX_CHUNKS)) ?
                                    TOT_W'(MAX_CHUNKS) : r_ctot;
                        n_host    = r_src;
                        n_rcv     = '0;
                        n_bytes   = '0;
                        n_len     = '0;
                        n_crc     = CRC_INIT;
                        n_idle    = '0;
                        n_row     = '0;
                        n_res_kind = KIND_ACK;
                        n_res_stat = ST_OK;
                        n_res_sess = r_tag;
                        n_res_seq  = 1'b0;
                        n_res_tot  = 1'b0;
                        n_state    = S_CLEAR;
                    end
                    OP_CHUNK: begin
                        if (r_phase == PH_RECV && r_tag == r_session) begin
                            n_idle    = '0;
                            crc_start = 1'b1;
                            n_state   = S_CRC;
                        end
                    end
                    OP_APPLY: begin
                        if (r_phase != PH_IDLE && r_tag == r_session) begin
                            n_res_sess = r_session;
                            n_res_stat = ST_OK;
                            n_res_seq  = 1'b0;
                            n_res_tot  = 1'b1;
                            if (r_rcv < r_total) begin
                                n_res_kind = KIND_STATUS;
                            end else begin
                                n_res_kind = KIND_GO;
                                n_phase    = PH_APPLY;
                            end
                            n_state = S_EMIT;
                        end
                    end
                    OP_ABORT: begin
                        drop = 1'b1;
                    end
                    OP_TICK: begin
                        if (r_phase != PH_IDLE) begin
                            n_idle = idle_inc;
                            if (idle_inc > timeout) begin
                                drop = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CLEAR: begin
                // zero one map row per cycle
                ram_we    = 1'b1;
                ram_waddr = r_row;
                ram_wdata = '0;
                n_row     = r_row + 1'b1;
                if (r_row == MAP_RW'(MAP_ROWS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_CRC: begin
                if (crc_done) begin
                    n_len = (r_len == '1) ? r_len : r_len + 1'b1;
                    n_crc = crc_out;
                    n_state = r_last ? S_JUDGE : S_IDLE;
                end
            end
            S_JUDGE: begin
                // restart chunk accumulation, judge the finished chunk
                n_len      = '0;
                n_crc      = CRC_INIT;
                n_res_kind = KIND_ACK;
                n_res_sess = r_session;
                n_res_seq  = 1'b1;
                n_res_tot  = 1'b0;
                n_state    = S_EMIT;
                if (r_seq >= {{(SEQ_W - TOT_W){1'b0}}, r_total}) begin
                    n_res_stat = ST_BAD_SEQ;
                end else if (ram_rdata[seq_bit]) begin
                    n_res_stat = ST_OK;
                end else if (r_crc != r_ecrc) begin
                    n_res_stat = ST_CRC_ERR;
                end else if (!r_sok) begin
                    n_res_stat = ST_NO_SPACE;
                    drop       = 1'b1;
                end else begin
                    n_res_stat = ST_OK;
                    ram_we     = 1'b1;
                    n_rcv      = r_rcv + 1'b1;
                    n_bytes    = byte_sum[CNT_W] ? '1 : byte_sum[CNT_W-1:0];
                end
            end
            S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (drop) begin
            n_phase   = PH_IDLE;
            n_session = '0;
            n_total   = '0;
            n_rcv     = '0;
            n_bytes   = '0;
            n_len     = '0;
            n_host    = '0;
            n_crc     = CRC_INIT;
            n_idle    = '0;
        end
    end

    assign n_o_valid = out_load | (r_o_valid & ~i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_session <= '0;
            r_total   <= '0;
            r_rcv     <= '0;
            r_bytes   <= '0;
            r_len     <= '0;
            r_host    <= '0;
            r_crc     <= CRC_INIT;
            r_idle    <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_session <= n_session;
            r_total   <= n_total;
            r_rcv     <= n_rcv;
            r_bytes   <= n_bytes;
            r_len     <= n_len;
            r_host    <= n_host;
            r_crc     <= n_crc;
            r_idle    <= n_idle;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_kind <= n_res_kind;
        r_res_stat <= n_res_stat;
        r_res_sess <= n_res_sess;
        r_res_seq  <= n_res_seq;
        r_res_tot  <= n_res_tot;
        if (out_load) begin
            r_o_kind  <= r_res_kind;
            r_o_dest  <= r_src;
            r_o_sess  <= r_res_sess;
            r_o_seq   <= r_res_seq ? r_seq : '0;
            r_o_stat  <= r_res_stat;
            r_o_done  <= r_rcv;
            r_o_tot   <= r_res_tot ? r_total : '0;
            r_o_bytes <= r_bytes;
            r_o_phase <= r_phase;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_result_kind      = r_o_kind;
    assign o_dest_addr        = r_o_dest;
    assign o_session_out      = r_o_sess;
    assign o_seq_out          = r_o_seq;
    assign o_ack_status       = r_o_stat;
    assign o_chunks_done      = r_o_done;
    assign o_chunks_total_out = r_o_tot;
    assign o_bytes_done       = r_o_bytes;
    assign o_phase_out        = r_o_phase;

endmodule

### design/cur_chk.sv
// Port-level checker for the chunked update receiver, bound to the top level.
module cur_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [cur_pkg::KIND_W-1:0]  o_result_kind,
    input logic [cur_pkg::SEQ_W-1:0]   o_seq_out,
    input logic [cur_pkg::STAT_W-1:0]  o_ack_status,
    input logic [cur_pkg::TOT_W-1:0]   o_chunks_done,
    input logic [cur_pkg::TOT_W-1:0]   o_chunks_total_out,
    input logic [cur_pkg::CNT_W-1:0]   o_bytes_done,
    input logic [cur_pkg::PH_W-1:0]    o_phase_out
);
    import cur_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_kind) &&
        $stable(o_seq_out) && $stable(o_chunks_done) && $stable(o_bytes_done))
        else $error("result changed while stalled");

    a_ack_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_ACK |-> o_chunks_total_out == '0)
        else $error("ack carries a chunk total");

    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_ACK |-> o_seq_out == '0 &&
        o_ack_status == ST_OK)
        else $error("status or go carries ack fields");

    a_go_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_GO |-> o_phase_out == PH_APPLY &&
        o_chunks_done >= o_chunks_total_out)
        else $error("go with chunks missing");

    a_no_space_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_ACK && o_ack_status == ST_NO_SPACE |->
        o_phase_out == PH_IDLE && o_chunks_done == '0 && o_bytes_done == '0)
        else $error("store failure left the session open");

endmodule

bind chunked_update_receiver cur_chk u_cur_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_result_kind      (o_result_kind),
    .o_seq_out          (o_seq_out),
    .o_ack_status       (o_ack_status),
    .o_chunks_done      (o_chunks_done),
    .o_chunks_total_out (o_chunks_total_out),
    .o_bytes_done       (o_bytes_done),
    .o_phase_out        (o_phase_out)
);

### test/tb_chunked_update_receiver.sv
// Self-checking testbench of the chunked update receiver, with a scoreboard that predicts each result.
module tb_chunked_update_receiver;
    import cur_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTS = 100;
    localparam t_op OP_BAD_LO = 3'd5;
    localparam t_op OP_BAD_HI = 3'd7;
    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    typedef struct {
        t_op                 op;
        logic [TAG_W-1:0]    tag;
        logic [TOT_W-1:0]    total;
        logic [SEQ_W-1:0]    seq;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [CRC_W-1:0]    crc;
        logic                store_ok;
        logic [ADDR_W-1:0]   src;
    } t_upd_cmd;

    typedef struct {
        t_kind               kind;
        logic [ADDR_W-1:0]   dest;
        logic [TAG_W-1:0]    sess;
        logic [SEQ_W-1:0]    seq;
        t_stat               status;
        logic [TOT_W-1:0]    done;
        logic [TOT_W-1:0]    total;
        logic [CNT_W-1:0]    bytes;
        t_phase              phase;
    } t_upd_result;

    class update_scoreboard;
        t_phase              phase;
        logic [TAG_W-1:0]    sess;
        logic [TOT_W-1:0]    total;
        logic [TOT_W-1:0]    rcv_cnt;
        logic [CNT_W-1:0]    bytes;
        logic [LEN_W-1:0]    clen;
        logic [ADDR_W-1:0]   host;
        logic [CRC_W-1:0]    crc_run;
        logic [CNT_W-1:0]    idle_ms;
        logic [CNT_W-1:0]    timeout_ms;
        bit                  got_chunk [MAX_CHUNKS];
        t_upd_result         expected_q [$];
        int                  errors;
        int unsigned         effective;

        function new();
            timeout_ms = TIMEOUT_RST;
            got_chunk = '{default: 1'b0};
            errors = 0;
            effective = 0;
            drop_session();
        endfunction

        static function logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] crc,
                                                      logic [BYTE_W-1:0] b);
            crc = crc ^ {b, 8'h00};
            repeat (8) begin
                if ((crc & CRC_TOP) != 0) crc = (crc << 1) ^ CRC_POLY;
                else crc = crc << 1;
            end
            return crc;
        endfunction

        function void drop_session();
            phase = PH_IDLE;
            sess = '0;
            total = '0;
            rcv_cnt = '0;
            bytes = '0;
            clen = '0;
            host = '0;
            crc_run = CRC_INIT;
            idle_ms = '0;
        endfunction

        function t_upd_result make_result(t_kind kind, logic [ADDR_W-1:0] dest,
                                          logic [TAG_W-1:0] s, logic [SEQ_W-1:0] seq,
                                          t_stat status, logic [TOT_W-1:0] tot);
            t_upd_result r;
            r.kind = kind;
            r.dest = dest;
            r.sess = s;
            r.seq = seq;
            r.status = status;
            r.done = rcv_cnt;
            r.total = tot;
            r.bytes = bytes;
            r.phase = phase;
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one accepted item and queue its result, if any.
        function void note_input(t_upd_cmd c);
            logic [TAG_W-1:0] s;
            logic [LEN_W-1:0] len;
            logic [CRC_W-1:0] crc;
            bit acted;
            acted = 1'b1;
            case (c.op)
                OP_BEGIN: begin
                    drop_session();
                    sess = c.tag;
                    total = (c.total > MAX_CHUNKS) ? TOT_W'(MAX_CHUNKS) : c.total;
                    host = c.src;
                    got_chunk = '{default: 1'b0};
                    phase = PH_RECV;
                    expected_q.push_back(make_result(KIND_ACK, c.src, sess, '0, ST_OK, '0));
                end
                OP_CHUNK: begin
                    if (phase != PH_RECV || c.tag != sess) begin
                        acted = 1'b0;
                    end else begin
                        idle_ms = '0;
                        crc_run = crc16_step(crc_run, c.data);
                        if (clen != '1) clen = clen + 1'b1;
                        if (c.last) begin
                            len = clen;
                            crc = crc_run;
                            clen = '0;
                            crc_run = CRC_INIT;
                            s = sess;
                            if (c.seq >= total) begin
                                expected_q.push_back(make_result(KIND_ACK, c.src, s, c.seq,
                                                                 ST_BAD_SEQ, '0));
                            end else if (got_chunk[c.seq]) begin
                                expected_q.push_back(make_result(KIND_ACK, c.src, s, c.seq,
                                                                 ST_OK, '0));
                            end else if (crc != c.crc) begin
                                expected_q.push_back(make_result(KIND_ACK, c.src, s, c.seq,
                                                                 ST_CRC_ERR, '0));
                            end else if (!c.store_ok) begin
                                drop_session();
                                expected_q.push_back(make_result(KIND_ACK, c.src, s, c.seq,
                                                                 ST_NO_SPACE, '0));
                            end else begin
                                got_chunk[c.seq] = 1'b1;
                                rcv_cnt = rcv_cnt + 1'b1;
                                if (bytes > ('1 - CNT_W'(len))) bytes = '1;
                                else bytes = bytes + CNT_W'(len);
                                expected_q.push_back(make_result(KIND_ACK, c.src, s, c.seq,
                                                                 ST_OK, '0));
                            end
                        end
                    end
                end
                OP_APPLY: begin
                    if (phase == PH_IDLE || c.tag != sess) begin
                        acted = 1'b0;
                    end else if (rcv_cnt < total) begin
                        expected_q.push_back(make_result(KIND_STATUS, c.src, sess, '0,
                                                         ST_OK, total));
                    end else begin
                        phase = PH_APPLY;
                        expected_q.push_back(make_result(KIND_GO, c.src, sess, '0,
                                                         ST_OK, total));
                    end
                end
                OP_ABORT: drop_session();
                OP_TICK: begin
                    if (phase == PH_IDLE) begin
                        acted = 1'b0;
                    end else begin
                        if (idle_ms != '1) idle_ms = idle_ms + 1'b1;
                        if (idle_ms > timeout_ms) drop_session();
                    end
                end
                default: acted = 1'b0;
            endcase
            if (acted) effective++;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] seen, logic [31:0] want);
            if (seen !== want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, want));
        endtask

        task check_result(t_upd_result r);
            t_upd_result e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result, kind %0d seq %0d", r.kind, r.seq));
            end else begin
                e = expected_q.pop_front();
                compare_field("result_kind", 32'(r.kind), 32'(e.kind));
                compare_field("dest_addr", 32'(r.dest), 32'(e.dest));
                compare_field("session_out", r.sess, e.sess);
                compare_field("seq_out", 32'(r.seq), 32'(e.seq));
                compare_field("ack_status", 32'(r.status), 32'(e.status));
                compare_field("chunks_done", 32'(r.done), 32'(e.done));
                compare_field("chunks_total_out", 32'(r.total), 32'(e.total));
                compare_field("bytes_done", r.bytes, e.bytes);
                compare_field("phase_out", 32'(r.phase), 32'(e.phase));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_opcode;
    logic [TAG_W-1:0]    i_session_tag;
    logic [TOT_W-1:0]    i_chunk_total;
    logic [SEQ_W-1:0]    i_seq_index;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                i_last_byte;
    logic [CRC_W-1:0]    i_chunk_crc;
    logic                i_store_ok;
    logic [ADDR_W-1:0]   i_source_addr;
    logic                o_valid;
    logic                i_ready;
    logic [KIND_W-1:0]   o_result_kind;
    logic [ADDR_W-1:0]   o_dest_addr;
    logic [TAG_W-1:0]    o_session_out;
    logic [SEQ_W-1:0]    o_seq_out;
    logic [STAT_W-1:0]   o_ack_status;
    logic [TOT_W-1:0]    o_chunks_done;
    logic [TOT_W-1:0]    o_chunks_total_out;
    logic [CNT_W-1:0]    o_bytes_done;
    logic [PH_W-1:0]     o_phase_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    update_scoreboard sb = new();
    int tx_idle_pct = 23;
    int rx_idle_pct = 55;
    int quiet_cycles = 0;

    chunked_update_receiver u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_session_tag(i_session_tag), .i_chunk_total(i_chunk_total),
        .i_seq_index(i_seq_index), .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .i_chunk_crc(i_chunk_crc), .i_store_ok(i_store_ok), .i_source_addr(i_source_addr),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_kind(o_result_kind), .o_dest_addr(o_dest_addr),
        .o_session_out(o_session_out), .o_seq_out(o_seq_out), .o_ack_status(o_ack_status),
        .o_chunks_done(o_chunks_done), .o_chunks_total_out(o_chunks_total_out),
        .o_bytes_done(o_bytes_done), .o_phase_out(o_phase_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: stall at random per the current idle rate.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_upd_cmd c;
        t_upd_result r;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_valid && o_ready) begin
                c.op = i_opcode;
                c.tag = i_session_tag;
                c.total = i_chunk_total;
                c.seq = i_seq_index;
                c.data = i_data_byte;
                c.last = i_last_byte;
                c.crc = i_chunk_crc;
                c.store_ok = i_store_ok;
                c.src = i_source_addr;
                sb.note_input(c);
                quiet_cycles = 0;
            end
            if (o_valid && i_ready) begin
                r.kind = o_result_kind;
                r.dest = o_dest_addr;
                r.sess = o_session_out;
                r.seq = o_seq_out;
                r.status = o_ack_status;
                r.done = o_chunks_done;
                r.total = o_chunks_total_out;
                r.bytes = o_bytes_done;
                r.phase = o_phase_out;
                sb.check_result(r);
                quiet_cycles = 0;
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_upd_cmd build_cmd(t_op op, logic [TAG_W-1:0] tag,
                                           logic [TOT_W-1:0] total, logic [SEQ_W-1:0] seq,
                                           logic [BYTE_W-1:0] data, logic last,
                                           logic [CRC_W-1:0] crc, logic store_ok,
                                           logic [ADDR_W-1:0] src);
        t_upd_cmd c;
        c.op = op;
        c.tag = tag;
        c.total = total;
        c.seq = seq;
        c.data = data;
        c.last = last;
        c.crc = crc;
        c.store_ok = store_ok;
        c.src = src;
        return c;
    endfunction

    function automatic t_upd_cmd random_cmd(logic [TAG_W-1:0] cur_tag);
        return build_cmd(t_op'($urandom_range(OP_BEGIN, OP_BAD_HI)),
                         $urandom_range(0, 1) ? cur_tag : TAG_W'($urandom),
                         TOT_W'($urandom_range(0, 8191)),
                         $urandom_range(0, 1) ? SEQ_W'($urandom_range(0, 7))
                                              : SEQ_W'($urandom_range(0, 65535)),
                         BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                         CRC_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                         ADDR_W'($urandom_range(0, 65535)));
    endfunction

    // Enter at a falling edge, return at the falling edge after acceptance with valid held.
    task automatic push_item(input t_upd_cmd c);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = c.op;
        i_session_tag = c.tag;
        i_chunk_total = c.total;
        i_seq_index = c.seq;
        i_data_byte = c.data;
        i_last_byte = c.last;
        i_chunk_crc = c.crc;
        i_store_ok = c.store_ok;
        i_source_addr = c.src;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_chunk(input logic [TAG_W-1:0] tag, input logic [SEQ_W-1:0] seq,
                              input int nbytes, input bit good_crc, input bit store_ok,
                              input logic [ADDR_W-1:0] src);
        logic [CRC_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        bit fin;
        int i;
        crc = CRC_INIT;
        for (i = 0; i < nbytes; i++) begin
            b = BYTE_W'($urandom);
            fin = (i == nbytes - 1);
            crc = update_scoreboard::crc16_step(crc, b);
            // Only the last byte carries a meaningful sequence, CRC and store flag.
            push_item(build_cmd(OP_CHUNK, tag, TOT_W'($urandom),
                                fin ? seq : SEQ_W'($urandom), b, fin,
                                !fin ? CRC_W'($urandom) :
                                good_crc ? crc : crc ^ (16'h1 << $urandom_range(0, 15)),
                                fin ? store_ok : 1'($urandom_range(0, 1)), src));
        end
    endtask

    task automatic push_op(input t_op op, input logic [TAG_W-1:0] tag,
                           input logic [ADDR_W-1:0] src);
        push_item(build_cmd(op, tag, TOT_W'($urandom), SEQ_W'($urandom), BYTE_W'($urandom),
                            1'($urandom_range(0, 1)), CRC_W'($urandom),
                            1'($urandom_range(0, 1)), src));
    endtask

    task automatic hold_until_drained();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = TIMEOUT_ADDR;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (wr) sb.timeout_ms = wdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_timeout_reg(input logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== want) sb.report($sformatf("timeout_ms reads 0x%0h, expected 0x%0h", rd, want));
    endtask

    task automatic set_timeout(input logic [31:0] value);
        logic [31:0] rd;
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_access(1'b1, value, rd);
        check_timeout_reg(value);
    endtask

    task automatic run_directed();
        t_op op;
        logic [TAG_W-1:0] tag;
        // Ignored while idle: chunk, tick and the unused opcodes with every field high.
        push_item(build_cmd(OP_CHUNK, '0, '0, '0, '0, 1'b1, '0, 1'b0, '0));
        push_item(build_cmd(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0));
        for (op = OP_BAD_LO; op <= OP_BAD_HI && op >= OP_BAD_LO; op++)
            push_item(build_cmd(op, '1, '1, '1, '1, 1'b1, '1, 1'b1, '1));
        // Announced total above the map size saturates; huge sequence is out of range.
        push_item(build_cmd(OP_BEGIN, '1, '1, '1, '1, 1'b1, '1, 1'b1, '1));
        send_chunk('0, '0, 1, 1'b1, 1'b1, '1);
        send_chunk('1, '1, 1, 1'b1, 1'b1, '1);
        push_op(OP_APPLY, '1, '0);
        // Normal two-chunk session with duplicate, CRC error and retry.
        tag = $urandom;
        push_item(build_cmd(OP_BEGIN, tag, TOT_W'(2), '0, '0, 1'b0, '0, 1'b0, '0));
        send_chunk(tag, SEQ_W'(0), 2, 1'b1, 1'b1, 16'h0001);
        send_chunk(tag, SEQ_W'(0), 1, 1'b1, 1'b1, 16'h0001);
        send_chunk(tag, SEQ_W'(1), 2, 1'b0, 1'b1, 16'h0001);
        push_op(OP_APPLY, tag, 16'h0002);
        send_chunk(tag, SEQ_W'(1), 1, 1'b1, 1'b1, 16'h0001);
        push_op(OP_APPLY, tag, 16'h0002);
        push_op(OP_APPLY, tag, 16'h0003);
        send_chunk(tag, SEQ_W'(0), 1, 1'b1, 1'b1, 16'h0001);
        // Idle past the timeout drops the session, so the apply after it is ignored.
        repeat (4) push_op(OP_TICK, '0, '0);
        push_op(OP_APPLY, tag, 16'h0002);
        // Empty session goes straight to apply.
        push_item(build_cmd(OP_BEGIN, tag, '0, '0, '0, 1'b0, '0, 1'b0, 16'h0004));
        push_op(OP_APPLY, tag, 16'h0004);
        // Store failure drops the session; abort does too.
        push_item(build_cmd(OP_BEGIN, tag, TOT_W'(3), '0, '0, 1'b0, '0, 1'b0, 16'h0005));
        send_chunk(tag, SEQ_W'(2), 1, 1'b1, 1'b0, 16'h0005);
        push_item(build_cmd(OP_BEGIN, tag, TOT_W'(3), '0, '0, 1'b0, '0, 1'b0, 16'h0005));
        push_op(OP_ABORT, ~tag, '0);
        push_op(OP_APPLY, tag, 16'h0005);
    endtask

    task automatic run_session();
        logic [TAG_W-1:0] tag;
        logic [ADDR_W-1:0] host;
        logic [ADDR_W-1:0] src;
        int unsigned n_chunks;
        int unsigned k;
        int tries;
        bit good;
        bit sok;
        tag = $urandom;
        host = ADDR_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) == 0) begin
            // A short burst of noise between sessions.
            repeat ($urandom_range(1, 4)) push_item(random_cmd(tag));
            return;
        end
        case ($urandom_range(0, 19))
            0: n_chunks = 0;
            1: n_chunks = $urandom_range(7, 16);
            default: n_chunks = $urandom_range(1, 5);
        endcase
        push_item(build_cmd(OP_BEGIN, tag, TOT_W'(n_chunks), SEQ_W'($urandom),
                            BYTE_W'($urandom), 1'($urandom_range(0, 1)), CRC_W'($urandom),
                            1'($urandom_range(0, 1)), host));
        for (k = 0; k < n_chunks; k++) begin
            tries = 0;
            do begin
                good = ($urandom_range(0, 9) != 0) || (tries >= 2);
                sok = ($urandom_range(0, 49) != 0);
                src = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom) : host;
                send_chunk(tag, SEQ_W'(k), $urandom_range(1, 4), good, sok, src);
                tries++;
            end while (!good);
            if (!sok) return;
            case ($urandom_range(0, 19))
                0, 1: send_chunk(tag, SEQ_W'(k), $urandom_range(1, 2), 1'b1, 1'b1, host);
                2: send_chunk(tag, SEQ_W'(n_chunks + $urandom_range(0, 3)), 1, 1'b1, 1'b1,
                              host);
                3: push_op(OP_TICK, TAG_W'($urandom), ADDR_W'($urandom));
                4: push_op(OP_APPLY, tag, host);
                5: push_item(build_cmd($urandom_range(0, 1) ? OP_CHUNK
                                           : t_op'($urandom_range(OP_BAD_LO, OP_BAD_HI)),
                                       tag ^ (32'h1 << $urandom_range(0, 31)),
                                       TOT_W'($urandom), SEQ_W'(k), BYTE_W'($urandom), 1'b1,
                                       CRC_W'($urandom), 1'b1, host));
                default: ;
            endcase
        end
        if ($urandom_range(0, 9) != 0) push_op(OP_APPLY, tag, host);
        if ($urandom_range(0, 3) == 0) push_op(OP_APPLY, tag, ADDR_W'($urandom));
        if ($urandom_range(0, 6) == 0) push_op(OP_ABORT, TAG_W'($urandom), ADDR_W'($urandom));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) push_op(OP_TICK, TAG_W'($urandom), ADDR_W'($urandom));
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned start;
        start = sb.effective;
        while (sb.effective - start < target / 2) run_session();
        // Hold the sender until the block has answered everything.
        hold_until_drained();
        while (sb.effective - start < target) run_session();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_TICK;
        i_session_tag = '0;
        i_chunk_total = '0;
        i_seq_index = '0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_chunk_crc = '0;
        i_store_ok = 1'b0;
        i_source_addr = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_timeout_reg(TIMEOUT_RST);
        tx_idle_pct = 23;
        rx_idle_pct = 55;
        set_timeout(32'd3);
        run_directed();

        set_timeout(32'd1);
        run_random(317);

        tx_idle_pct = 55;
        rx_idle_pct = 23;
        set_timeout('1);
        run_random(317);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_timeout(32'd20);
        run_random(317);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
